// ----- src/ppdm_pkg.sv -----
// types and codes shared by the projection depth map block
// request and response beats, operation and status codes; no dependencies
package ppdm_pkg;

   localparam int MAX_COLS_DEF = 512;
   localparam int MAX_ROWS_DEF = 512;
   localparam int COEF_BITS    = 21;
   localparam int ROW_BITS     = 63;
   localparam int CSR_IDX_BITS = 3;

   typedef enum logic [1:0] {
      FUNC_PROJECT = 2'd0,
      FUNC_READ    = 2'd1,
      FUNC_CLEAR   = 2'd2,
      FUNC_NOP     = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_WRITTEN  = 3'd0,
      ST_OUTSIDE  = 3'd1,
      ST_ZERO_DIV = 3'd2,
      ST_READ     = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ROW0   = 3'd0,
      CSR_ROW1   = 3'd1,
      CSR_ROW2   = 3'd2,
      CSR_WIDTH  = 3'd3,
      CSR_HEIGHT = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [8:0]         read_col;
      logic [8:0]         read_row;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [8:0]         pixel_col;
      logic [8:0]         pixel_row;
      logic signed [31:0] depth_value;
   } rsp_type;

endpackage

// ----- src/point_projection_depth_map.sv -----
// projection of points through a 3x3 camera matrix into a depth store
// depends on ppdm_pkg for beat types and codes
//
// A command beat is taken when start is high and busy is low; each command
// (but the unused code, which gives nothing) returns one response beat with
// rsp_valid high for exactly one cycle, which the receiver cannot stall.
// After reset the store is swept to zero, one entry a cycle, over all
// MAX_COLS*MAX_ROWS entries (262144 at the defaults) with busy high.
// A projection runs nine products through one shared 21x32 multiplier, the
// divisor check, two 54-step restoring divisions on one shared subtractor,
// the address, the write and the response; a zero divisor or a point outside
// the map ends it early. A read goes through the address, the memory read and
// the response, a clear sweeps every entry through the single memory write port.
module point_projection_depth_map #(
   parameter int MAX_COLS = ppdm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = ppdm_pkg::MAX_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  ppdm_pkg::req_type                   req,
   output logic                                rsp_valid,
   output ppdm_pkg::rsp_type                   rsp,
   input  logic                                csr_we,
   input  logic [ppdm_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [ppdm_pkg::ROW_BITS-1:0]       csr_wdata
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int ADW   = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CB    = ppdm_pkg::COEF_BITS;
   localparam int PW    = CB + 32;       // product width
   localparam int SW    = PW + 2;        // sum of three products
   localparam int DW    = SW - 1;        // magnitude width
   localparam int CNTW  = $clog2(DW + 1);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_MUL, S_ACC, S_CHK, S_DIV, S_QUOT,
      S_ADDR, S_MEM, S_RRSP, S_CLR
   } state_type;

   state_type                     state_ff;
   logic [ppdm_pkg::ROW_BITS-1:0] row0_ff, row1_ff, row2_ff;
   logic [9:0]                    width_ff, height_ff;
   logic signed [31:0]            x_ff, y_ff, z_ff;
   logic [1:0]                    mrow_ff, mcol_ff;
   logic signed [PW-1:0]          prod_ff;
   logic signed [SW-1:0]          p_ff [3];
   logic                          dsel_ff;
   logic [DW-1:0]                 rem_ff, dq_ff, div_ff;
   logic [CNTW-1:0]               cnt_ff;
   logic [CW-1:0]                 u_ff;
   logic [RW-1:0]                 v_ff;
   logic                          is_write_ff;
   logic [ADW-1:0]                addr_ff, clr_ff;
   logic                          rsp_valid_ff;
   ppdm_pkg::rsp_type             rsp_ff;
   logic [31:0]                   depth_mem [DEPTH];
   logic [31:0]                   mem_q_ff;

   logic [ppdm_pkg::ROW_BITS-1:0] row_sel;
   logic signed [CB-1:0]          coef_sel;
   logic signed [31:0]            opnd_sel;
   logic signed [PW-1:0]          prod_in;
   logic [DW:0]                   rem_sh, rem_diff;
   logic                          rem_ge;
   logic [DW-1:0]                 rem_in;
   logic signed [SW-1:0]          p_num;
   logic                          q_neg, q_inside;
   logic                          clr_last;
   logic                          mem_we;
   logic [ADW-1:0]                mem_wa;
   logic [31:0]                   mem_wd;

   function automatic logic [DW-1:0] magnitude(input logic signed [SW-1:0] a);
      logic signed [SW-1:0] m;
      m = (a < 0) ? -a : a;
      return m[DW-1:0];
   endfunction

   // shared multiplier operand selection
   always_comb begin
      case (mrow_ff)
         2'd0:    row_sel = row0_ff;
         2'd1:    row_sel = row1_ff;
         default: row_sel = row2_ff;
      endcase
      case (mcol_ff)
         2'd0: begin
            coef_sel = row_sel[CB-1:0];
            opnd_sel = x_ff;
         end
         2'd1: begin
            coef_sel = row_sel[2*CB-1:CB];
            opnd_sel = y_ff;
         end
         default: begin
            coef_sel = row_sel[3*CB-1:2*CB];
            opnd_sel = z_ff;
         end
      endcase
      prod_in = coef_sel * opnd_sel;
   end

   // restoring divider step
   always_comb begin
      rem_sh   = {rem_ff, dq_ff[DW-1]};
      rem_diff = rem_sh - {1'b0, div_ff};
      rem_ge   = !rem_diff[DW];
      rem_in   = rem_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
   end

   // quotient in dq_ff once the division is done; a zero quotient has no sign
   always_comb begin
      p_num = dsel_ff ? p_ff[1] : p_ff[0];
      q_neg = p_num[SW-1] ^ p_ff[2][SW-1];
      if (dsel_ff)
         q_inside = ((dq_ff == '0) || !q_neg) && dq_ff < DW'(height_ff) &&
                    dq_ff < DW'(MAX_ROWS);
      else
         q_inside = ((dq_ff == '0) || !q_neg) && dq_ff < DW'(width_ff) &&
                    dq_ff < DW'(MAX_COLS);
   end

   assign clr_last = (clr_ff == ADW'(DEPTH - 1));
   assign mem_we   = (state_ff == S_INIT) || (state_ff == S_CLR) ||
                     (state_ff == S_MEM && is_write_ff);
   assign mem_wa   = (state_ff == S_MEM) ? addr_ff : clr_ff;
   assign mem_wd   = (state_ff == S_MEM) ? z_ff : '0;

   always_ff @(posedge clock) begin
      if (mem_we)
         depth_mem[mem_wa] <= mem_wd;
      mem_q_ff <= depth_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         row0_ff      <= ppdm_pkg::ROW_BITS'(256);
         row1_ff      <= ppdm_pkg::ROW_BITS'(64'd536870912);
         row2_ff      <= ppdm_pkg::ROW_BITS'(64'd1125899906842624);
         width_ff     <= 10'd512;
         height_ff    <= 10'd512;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               ppdm_pkg::CSR_ROW0:   row0_ff   <= csr_wdata;
               ppdm_pkg::CSR_ROW1:   row1_ff   <= csr_wdata;
               ppdm_pkg::CSR_ROW2:   row2_ff   <= csr_wdata;
               ppdm_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[9:0];
               ppdm_pkg::CSR_HEIGHT: height_ff <= csr_wdata[9:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_INIT: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_last) begin
                  clr_ff   <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  x_ff    <= req.point_x;
                  y_ff    <= req.point_y;
                  z_ff    <= req.point_z;
                  mrow_ff <= 2'd0;
                  mcol_ff <= 2'd0;
                  p_ff[0] <= '0;
                  p_ff[1] <= '0;
                  p_ff[2] <= '0;
                  unique case (req.func)
                     ppdm_pkg::FUNC_PROJECT: state_ff <= S_MUL;
                     ppdm_pkg::FUNC_READ: begin
                        is_write_ff <= 1'b0;
                        u_ff        <= CW'(req.read_col);
                        v_ff        <= RW'(req.read_row);
                        if (10'(req.read_col) < width_ff && int'(req.read_col) < MAX_COLS &&
                            10'(req.read_row) < height_ff && int'(req.read_row) < MAX_ROWS)
                           state_ff <= S_ADDR;
                        else begin
                           rsp_valid_ff          <= 1'b1;
                           rsp_ff.status         <= ppdm_pkg::ST_OUTSIDE;
                           rsp_ff.pixel_col      <= req.read_col;
                           rsp_ff.pixel_row      <= req.read_row;
                           rsp_ff.depth_value    <= '0;
                        end
                     end
                     ppdm_pkg::FUNC_CLEAR: state_ff <= S_CLR;
                     default: ;
                  endcase
               end
            end
            S_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               p_ff[mrow_ff] <= p_ff[mrow_ff] + SW'(prod_ff);
               state_ff      <= S_MUL;
               if (mcol_ff == 2'd2) begin
                  mcol_ff <= 2'd0;
                  mrow_ff <= mrow_ff + 1'b1;
                  if (mrow_ff == 2'd2)
                     state_ff <= S_CHK;
               end else
                  mcol_ff <= mcol_ff + 1'b1;
            end
            S_CHK: begin
               if (p_ff[2] == '0) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff             <= '0;
                  rsp_ff.status      <= ppdm_pkg::ST_ZERO_DIV;
                  state_ff           <= S_IDLE;
               end else begin
                  dsel_ff  <= 1'b0;
                  dq_ff    <= magnitude(p_ff[0]);
                  div_ff   <= magnitude(p_ff[2]);
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= rem_in;
               dq_ff  <= {dq_ff[DW-2:0], rem_ge};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNTW'(DW - 1))
                  state_ff <= S_QUOT;
            end
            S_QUOT: begin
               if (!q_inside) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_ff        <= '0;
                  rsp_ff.status <= ppdm_pkg::ST_OUTSIDE;
                  state_ff      <= S_IDLE;
               end else if (!dsel_ff) begin
                  u_ff     <= dq_ff[CW-1:0];
                  dsel_ff  <= 1'b1;
                  dq_ff    <= magnitude(p_ff[1]);
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end else begin
                  v_ff        <= dq_ff[RW-1:0];
                  is_write_ff <= 1'b1;
                  state_ff    <= S_ADDR;
               end
            end
            S_ADDR: begin
               addr_ff  <= ADW'(int'(v_ff) * MAX_COLS + int'(u_ff));
               state_ff <= S_MEM;
            end
            S_MEM: begin
               if (is_write_ff) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.status      <= ppdm_pkg::ST_WRITTEN;
                  rsp_ff.pixel_col   <= 9'(u_ff);
                  rsp_ff.pixel_row   <= 9'(v_ff);
                  rsp_ff.depth_value <= '0;
                  state_ff           <= S_IDLE;
               end else
                  state_ff <= S_RRSP;
            end
            S_RRSP: begin
               rsp_valid_ff       <= 1'b1;
               rsp_ff.status      <= ppdm_pkg::ST_READ;
               rsp_ff.pixel_col   <= 9'(u_ff);
               rsp_ff.pixel_row   <= 9'(v_ff);
               rsp_ff.depth_value <= mem_q_ff;
               state_ff           <= S_IDLE;
            end
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_last) begin
                  clr_ff        <= '0;
                  rsp_valid_ff  <= 1'b1;
                  rsp_ff        <= '0;
                  rsp_ff.status <= ppdm_pkg::ST_CLEARED;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // a response beat only comes out while the block is idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response beat while busy");

   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp))
      else $error("response beat with unknown fields");

   a_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req.func != ppdm_pkg::FUNC_NOP &&
       req.func != ppdm_pkg::FUNC_READ) |=> busy)
      else $error("command taken without going busy");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_ff != '0))
      else $error("division started with zero divisor");

endmodule
